// ----- hw/rtl/csn1lh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// CSN.1 L/H bit writer package
// Shared item types, operation and symbol codes, and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package csn1lh_pkg;

  localparam int MAX_BYTES_DEF = 64;
  localparam int BYTE_W        = 8;
  localparam int CUR_W         = 10;
  localparam int LEN_W         = 7;
  localparam int CFG_AW        = 3;

  localparam logic [7:0]       PAD_PATTERN    = 8'h2b;
  localparam logic [LEN_W-1:0] BUFFER_LEN_RST = 7'd64;

  // Configuration register index (paddr[2]).
  localparam logic REG_BUFFER_LEN = 1'b0;

  localparam logic [2:0] OP_PUT_SYMS  = 3'd0;
  localparam logic [2:0] OP_PUT_VALUE = 3'd1;
  localparam logic [2:0] OP_PUT_AT    = 3'd2;
  localparam logic [2:0] OP_PAD       = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_L    = 2'd2;
  localparam logic [1:0] SYM_H    = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] symbols;
    logic [31:0] value;
    logic [5:0]  bit_count;
    logic [8:0]  bit_position;
    logic [5:0]  byte_index;
  } item_in_t;

  typedef struct packed {
    logic             status;
    logic [CUR_W-1:0] cursor;
    logic [7:0]       read_data;
  } item_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic bound;
    logic modify;
    logic clear;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic any;
    logic last_byte;
    logic clear_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/csn1_lh_bit_writer.sv -----
`default_nettype none
// Flow: an accepted item passes through PREP, BOUND and READ, then FINISH; done is registered
// from FINISH. Each store byte touched by a run takes a READ and a MODIFY state; reads,
// unused codes and empty runs go from READ straight to FINISH. No new item is taken while
// busy; the next item can be taken in the done cycle, when busy is already low.
// Bytes touched: at most 5 for symbol and value writes, 1 for positional, up to 64 for pad.
// Reset: after rst the store is cleared one byte per cycle, all MAX_BYTES bytes, with busy high.
// ----------------------------------------------------------------------------
// CSN.1 L/H bit writer
// Packs ZERO/ONE/L/H symbols MSB-first into a byte store at a bit cursor,
// with padding, positional writes and byte reads. APB-style length register.
// ----------------------------------------------------------------------------
module csn1_lh_bit_writer #(
  parameter int MAX_BYTES = csn1lh_pkg::MAX_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  csn1lh_pkg::item_in_t              item,
  output logic                              done,
  output csn1lh_pkg::item_out_t             result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csn1lh_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import csn1lh_pkg::*;

  logic [LEN_W-1:0] buffer_len;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_len <= BUFFER_LEN_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_LEN)) begin
      buffer_len <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUFFER_LEN) ? {25'b0, buffer_len} : 32'h0;

  csn1lh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  csn1lh_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .buffer_len (buffer_len),
    .cmd        (cmd),
    .stat       (stat),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the block is busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the block busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/csn1lh_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csn1lh_ram #(
  parameter int WIDTH = csn1lh_pkg::BYTE_W,
  parameter int DEPTH = csn1lh_pkg::MAX_BYTES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/csn1lh_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// CSN.1 L/H bit writer controller
// Sequences the clearing pass, run setup and the per-byte read-modify-write.
// ----------------------------------------------------------------------------
module csn1lh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  csn1lh_pkg::dp_stat_t stat,
  output logic                 busy,
  output logic                 done,
  output csn1lh_pkg::dp_cmd_t  cmd
);
  import csn1lh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_BOUND  = 7'b0001000,
    S_READ   = 7'b0010000,
    S_MODIFY = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_BOUND;
      end
      S_BOUND: begin
        cmd.bound  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        // The byte under the run is being read; a read item only needs this.
        priority if (stat.is_read) begin
          state_next = S_FINISH;
        end else if (stat.any) begin
          state_next = S_MODIFY;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = stat.last_byte ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/csn1lh_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// CSN.1 L/H bit writer datapath
// Bit cursor, run bounds, symbol source and the byte store with its
// read-modify-write merge.
// ----------------------------------------------------------------------------
module csn1lh_dp #(
  parameter int MAX_BYTES = csn1lh_pkg::MAX_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  csn1lh_pkg::item_in_t              item,
  input  logic [csn1lh_pkg::LEN_W-1:0]      buffer_len,
  input  csn1lh_pkg::dp_cmd_t               cmd,
  output csn1lh_pkg::dp_stat_t              stat,
  output csn1lh_pkg::item_out_t             result
);
  import csn1lh_pkg::*;

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [12:0] MAX_B = 13'(MAX_BYTES);

  function automatic logic sym_bit(input logic [1:0] sym, input logic [2:0] k);
    logic pb;
    pb = PAD_PATTERN[3'd7 - k];
    unique case (sym)
      SYM_ZERO: sym_bit = 1'b0;
      SYM_ONE:  sym_bit = 1'b1;
      SYM_L:    sym_bit = pb;
      SYM_H:    sym_bit = ~pb;
    endcase
  endfunction

  // Captured item and architectural cursor.
  item_in_t         in_r;
  logic [CUR_W-1:0] cursor;

  // Run setup.
  logic [CUR_W-1:0] n_r, start_r, lim_r, end_r, new_cur;
  logic [CUR_W:0]   sum_r;
  logic [63:0]      symvec_r;
  logic             pad_r, fail_r, any_r;
  logic [LEN_W-1:0] byte_addr;
  logic [AW-1:0]    clr_addr;

  logic [CUR_W-1:0] n_c, start_c, pos_e, pos_p1, lim_c;
  logic [LEN_W-1:0] usable;
  logic [31:0]      shv;
  logic [63:0]      symvec_c;

  logic [CUR_W-1:0] clip, end_c, end_m1;
  logic             fail_c, moves;

  logic [CUR_W-1:0] bp [8];
  logic [4:0]       bj [8];
  logic [1:0]       bs [8];
  logic [7:0]       new_byte;
  logic [7:0]       rdata;
  logic             idx_ok;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  // ---------------- setup: run length, start and symbol source ----------------
  assign pos_e  = {1'b0, in_r.bit_position};
  assign pos_p1 = pos_e + 10'd1;
  assign usable = ({6'b0, buffer_len} < MAX_B) ? buffer_len : LEN_W'(MAX_BYTES);
  assign lim_c  = {usable, 3'b000};

  always_comb begin
    start_c = cursor;
    unique case (in_r.operation)
      OP_PUT_SYMS:  n_c = (in_r.bit_count > 6'd16) ? 10'd16 : {4'b0, in_r.bit_count};
      OP_PUT_VALUE: n_c = (in_r.bit_count > 6'd32) ? 10'd32 : {4'b0, in_r.bit_count};
      OP_PUT_AT: begin
        n_c     = 10'd1;
        start_c = pos_e;
      end
      // Pad through bit_position; a position behind the cursor is a no-op.
      OP_PAD:       n_c = (pos_p1 > cursor) ? pos_p1 - cursor : 10'd0;
      default:      n_c = 10'd0;
    endcase
  end

  // Value bits go MSB-first: left-align the count, then stream bit j is bit 31-j.
  assign shv = in_r.value << (6'd32 - n_c[5:0]);

  always_comb begin
    if (in_r.operation == OP_PUT_VALUE) begin
      for (int j = 0; j < 32; j++) begin
        symvec_c[2*j +: 2] = {1'b0, shv[31-j]};
      end
    end else begin
      symvec_c = {32'b0, in_r.symbols};
    end
  end

  // ---------------- bounds: where the run actually stops ----------------
  assign clip   = (sum_r > {1'b0, lim_r}) ? lim_r : sum_r[CUR_W-1:0];
  assign end_c  = (clip > start_r) ? clip : start_r;
  assign fail_c = (sum_r > {1'b0, lim_r}) && (n_r != 10'd0) &&
                  ((in_r.operation == OP_PUT_SYMS) || (in_r.operation == OP_PUT_VALUE) ||
                   (in_r.operation == OP_PUT_AT));
  assign moves  = (in_r.operation == OP_PUT_SYMS) || (in_r.operation == OP_PUT_VALUE) ||
                  (in_r.operation == OP_PAD);

  // ---------------- byte merge ----------------
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bp[k] = {byte_addr, 3'(k)};
      bj[k] = 5'(bp[k] - start_r);
      bs[k] = pad_r ? SYM_L : symvec_r[{bj[k], 1'b0} +: 2];
      new_byte[7-k] = ((bp[k] >= start_r) && (bp[k] < end_r)) ?
                      sym_bit(bs[k], 3'(k)) : rdata[7-k];
    end
  end

  assign end_m1 = end_r - 10'd1;
  assign idx_ok = ({7'b0, in_r.byte_index} < MAX_B);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.finish) begin
        cursor <= new_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= item;
    end
    if (cmd.prep) begin
      n_r      <= n_c;
      start_r  <= start_c;
      sum_r    <= {1'b0, start_c} + {1'b0, n_c};
      lim_r    <= lim_c;
      symvec_r <= symvec_c;
      pad_r    <= (in_r.operation == OP_PAD);
    end
    if (cmd.bound) begin
      end_r     <= end_c;
      fail_r    <= fail_c;
      any_r     <= (end_c > start_r);
      new_cur   <= moves ? end_c : cursor;
      byte_addr <= (in_r.operation == OP_READ) ? {1'b0, in_r.byte_index}
                                               : start_r[CUR_W-1:3];
    end else if (cmd.modify) begin
      byte_addr <= byte_addr + 7'd1;
    end
    if (cmd.finish) begin
      result.status    <= fail_r ? STATUS_RANGE : STATUS_OK;
      result.cursor    <= new_cur;
      result.read_data <= ((in_r.operation == OP_READ) && idx_ok) ? rdata : 8'h00;
    end
  end

  // ---------------- byte store ----------------
  assign ram_we    = cmd.modify | cmd.clear;
  assign ram_waddr = cmd.clear ? clr_addr : AW'(byte_addr);
  assign ram_wdata = cmd.clear ? 8'h00 : new_byte;

  csn1lh_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(byte_addr)),
    .rdata (rdata)
  );

  assign stat.is_read    = (in_r.operation == OP_READ);
  assign stat.any        = any_r;
  assign stat.last_byte  = (byte_addr == end_m1[CUR_W-1:3]);
  assign stat.clear_last = (clr_addr == AW'(MAX_BYTES - 1));

endmodule
`default_nettype wire
